/* design/ctbt_pkg.sv */
// ctbt_pkg: shared types, field widths and conversion helpers for the calendar to bcd block
// used by the channel interfaces and by calendar_to_bcd_time_words_top
`timescale 1ns / 1ps

package ctbt_pkg;

  localparam int YearW = 14;
  localparam int ByteW = 8;
  localparam int YdayW = 9;
  localparam int Word0W = 18;
  localparam int Word1W = 22;
  localparam int Word2W = 22;

  // reciprocal of 100 for a 14-bit dividend: x / 100 == (x * 5243) >> 19
  localparam int RecipW = 13;
  localparam logic [RecipW-1:0] Recip100 = 13'd5243;
  localparam int RecipShift = 19;
  localparam int ProdW = YearW + RecipW;

  typedef struct packed {
    logic [YearW-1:0] year_value;
    logic [ByteW-1:0] month_num;
    logic [ByteW-1:0] day_num;
    logic [ByteW-1:0] weekday_code;
    logic [ByteW-1:0] hour_num;
    logic [ByteW-1:0] minute_num;
    logic [ByteW-1:0] second_num;
    logic             encode_enable_in;
    logic             decode_enable_in;
    logic             pps_clear_enable_in;
  } in_word_t;

  typedef struct packed {
    logic              date_valid;
    logic [Word0W-1:0] year_day_word;
    logic [Word1W-1:0] month_day_week_word;
    logic [Word2W-1:0] hms_word;
    logic              encode_enable_out;
    logic              decode_enable_out;
    logic              pps_clear_enable_out;
  } out_word_t;

  // saturate a byte at 99
  function automatic logic [6:0] clamp99(input logic [7:0] v);
    logic [6:0] r;
    r = (v > 8'd99) ? 7'd99 : v[6:0];
    return r;
  endfunction

  // two-digit bcd of a value at most 99: v / 10 == (v * 205) >> 11
  function automatic logic [7:0] bcd99(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  u;
    p = 15'(v) * 15'd205;
    t = p[14:11];
    u = v - 7'(t) * 7'd10;
    return {t, u[3:0]};
  endfunction

  // month length in a common year, zero for codes that name no month
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
      4'd2:                                      r = 5'd28;
      default:                                   r = 5'd0;
    endcase
    return r;
  endfunction

  // days in the months before m, common year
  function automatic logic [YdayW-1:0] days_before(input logic [3:0] m);
    logic [YdayW-1:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* design/ctbt_in_if.sv */
// ctbt_in_if: valid/ready channel carrying one calendar input word
// depends on ctbt_pkg for the payload type
`timescale 1ns / 1ps

interface ctbt_in_if import ctbt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* design/ctbt_out_if.sv */
// ctbt_out_if: valid/ready channel carrying one packed bcd result word
// depends on ctbt_pkg for the payload type
`timescale 1ns / 1ps

interface ctbt_out_if import ctbt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* design/calendar_to_bcd_time_words_top.sv */
// calendar_to_bcd_time_words_top: date check, day of year and bcd packing in three stages
// depends on ctbt_pkg, ctbt_in_if and ctbt_out_if
`timescale 1ns / 1ps

// usage
//   in_ch takes one calendar word per handshake: year, month, day, weekday,
//   hour, minute, second and three enable flags
//   out_ch gives exactly one result word per input word, in order: the date
//   valid flag, three packed bcd words and the enable flags; an invalid date
//   still gives a word, with date_valid low and every other field zero
// timing
//   three register stages; a word taken into stage 1 moves through stages 2
//   and 3, and out_ch.valid rises once it sits in the stage-3 output register
//   a new word is accepted every cycle while in_ch.ready is high; the rate is
//   set by the stage-1 multiply by the reciprocal of 100, the stage-2 month
//   table and the stage-3 day-of-year to bcd split, each one register stage deep
// stalls
//   each stage holds a valid bit; a stage loads when it is empty or when the
//   stage after it moves on, so bubbles collapse and a held output word never
//   blocks the earlier stages until all three are full
//   in_ch.ready drops only when every stage holds a word and out_ch.ready is low
// reset
//   rst (synchronous, active high) clears the stage valid bits; data
//   registers are not reset

module calendar_to_bcd_time_words_top import ctbt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ctbt_in_if.sink    in_ch,
  ctbt_out_if.source out_ch
);

  // stage valid bits and advance enables
  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  assign adv3 = !v3 || out_ch.ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_ch.ready = adv1;

  // stage 1: range checks, clamps, time bcd, reciprocal product of year
  logic [YearW-1:0] s1_year;
  logic [ProdW-1:0] s1_prod;
  logic [3:0]       s1_month;
  logic [4:0]       s1_day;
  logic             s1_ok;
  logic [7:0]       s1_month_bcd, s1_day_bcd;
  logic [6:0]       s1_week;
  logic [7:0]       s1_hour_bcd, s1_min_bcd, s1_sec_bcd;
  logic [2:0]       s1_flags;

  // stage 2: leap rule, month length check, day of year
  logic             s2_ok;
  logic [YdayW-1:0] s2_yday;
  logic [6:0]       s2_yr2;
  logic [7:0]       s2_month_bcd, s2_day_bcd;
  logic [6:0]       s2_week;
  logic [7:0]       s2_hour_bcd, s2_min_bcd, s2_sec_bcd;
  logic [2:0]       s2_flags;

  // stage 3: output register
  out_word_t s3_word;

  // stage 1 logic
  logic month_ok, day_ok;
  assign month_ok = (in_ch.payload.month_num >= 8'd1) && (in_ch.payload.month_num <= 8'd12);
  assign day_ok   = (in_ch.payload.day_num >= 8'd1) && (in_ch.payload.day_num <= 8'd31);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_ch.valid;
    end
    if (adv1) begin
      s1_year      <= in_ch.payload.year_value;
      s1_prod      <= ProdW'(in_ch.payload.year_value) * ProdW'(Recip100);
      s1_month     <= in_ch.payload.month_num[3:0];
      s1_day       <= in_ch.payload.day_num[4:0];
      s1_ok        <= month_ok && day_ok;
      s1_month_bcd <= bcd99(clamp99(in_ch.payload.month_num));
      s1_day_bcd   <= bcd99(clamp99(in_ch.payload.day_num));
      s1_week      <= in_ch.payload.weekday_code[6:0];
      s1_hour_bcd  <= bcd99(clamp99(in_ch.payload.hour_num));
      s1_min_bcd   <= bcd99(clamp99(in_ch.payload.minute_num));
      s1_sec_bcd   <= bcd99(clamp99(in_ch.payload.second_num));
      s1_flags     <= {in_ch.payload.encode_enable_in, in_ch.payload.decode_enable_in,
                       in_ch.payload.pps_clear_enable_in};
    end
  end

  // stage 2 logic: century count, year mod 100, leap rule, month length and day of year
  logic [7:0]       cent;
  logic [YearW-1:0] yr_rem;
  logic [6:0]       yr2;
  logic             leap;
  logic [4:0]       mlen;
  logic             feb_extra;
  logic [YdayW-1:0] yday;

  assign cent   = s1_prod[RecipShift +: 8];
  assign yr_rem = s1_year - YearW'(cent) * YearW'(100);
  assign yr2    = yr_rem[6:0];
  // divisible by 4 and not by 100, or divisible by 400
  assign leap   = ((s1_year[1:0] == 2'd0) && (yr2 != 7'd0)) ||
                  ((yr2 == 7'd0) && (cent[1:0] == 2'd0));
  assign mlen   = (s1_month == 4'd2 && leap) ? 5'd29 : month_len(s1_month);
  assign feb_extra = leap && (s1_month > 4'd2);
  assign yday   = days_before(s1_month) + YdayW'(s1_day) + YdayW'(feb_extra);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
    if (adv2) begin
      s2_ok        <= s1_ok && (s1_day <= mlen);
      s2_yday      <= yday;
      s2_yr2       <= yr2;
      s2_month_bcd <= s1_month_bcd;
      s2_day_bcd   <= s1_day_bcd;
      s2_week      <= s1_week;
      s2_hour_bcd  <= s1_hour_bcd;
      s2_min_bcd   <= s1_min_bcd;
      s2_sec_bcd   <= s1_sec_bcd;
      s2_flags     <= s1_flags;
    end
  end

  // stage 3 logic: day of year to three bcd digits, word packing
  logic [1:0]       hund;
  logic [YdayW-1:0] yd_rem;
  logic [9:0]       yd_bcd;
  out_word_t        word_next;

  always_comb begin
    if (s2_yday >= 9'd300) begin
      hund = 2'd3;
    end else if (s2_yday >= 9'd200) begin
      hund = 2'd2;
    end else if (s2_yday >= 9'd100) begin
      hund = 2'd1;
    end else begin
      hund = 2'd0;
    end
  end

  assign yd_rem = s2_yday - YdayW'(hund) * YdayW'(100);
  assign yd_bcd = {hund, bcd99(yd_rem[6:0])};

  always_comb begin
    word_next = '0;
    if (s2_ok) begin
      word_next.date_valid          = 1'b1;
      word_next.year_day_word       = {bcd99(s2_yr2), yd_bcd};
      // month and day fields overlap on bits 13 and 14 and are ored
      word_next.month_day_week_word = (Word1W'(s2_month_bcd) << 13) |
                                      (Word1W'(s2_day_bcd) << 7) | Word1W'(s2_week);
      word_next.hms_word            = (Word2W'(s2_hour_bcd) << 14) |
                                      (Word2W'(s2_min_bcd) << 7) | Word2W'(s2_sec_bcd);
      word_next.encode_enable_out   = s2_flags[2];
      word_next.decode_enable_out   = s2_flags[1];
      word_next.pps_clear_enable_out = s2_flags[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
    if (adv3) begin
      s3_word <= word_next;
    end
  end

  assign out_ch.valid   = v3;
  assign out_ch.payload = s3_word;

endmodule

/* tb/testbench.sv */
// testbench: self-checking bench for calendar_to_bcd_time_words_top, directed and random words
// depends on ctbt_pkg, ctbt_in_if, ctbt_out_if and the block under test
`timescale 1ns / 1ps

module testbench;
  import ctbt_pkg::*;

  // masks and limits of the packed bcd layout
  localparam int unsigned YdayMask   = 32'h3FF;
  localparam int unsigned WeekMask   = 32'h7F;
  localparam int unsigned BcdCeiling = 99;
  localparam int unsigned RandomWords = 1350;
  localparam int unsigned BlockWords  = 30;
  localparam int unsigned DrainEvery  = 300;
  // quiet wait after the last result word, to catch stray results
  localparam int unsigned TailCycles  = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ctbt_in_if  in_ch ();
  ctbt_out_if out_ch ();

  calendar_to_bcd_time_words_top DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result words still owed by the block, oldest first
  out_word_t pending_words[$];

  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned good_dates_sent = 0;
  int unsigned bad_dates_sent = 0;

  // idling switches: when set, that side inserts no random gap or stall
  bit send_no_gap = 1'b0;
  bit sink_no_stall = 1'b0;

  // gregorian rule on the full year value, not just the packed two digits
  function automatic bit is_leap_year(input int unsigned year);
    return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
  endfunction

  // zero for anything that is not a month
  function automatic int unsigned month_days(input int unsigned m, input bit leap);
    int unsigned n;
    case (m)
      1, 3, 5, 7, 8, 10, 12: n = 31;
      4, 6, 9, 11:           n = 30;
      2:                     n = leap ? 29 : 28;
      default:               n = 0;
    endcase
    return n;
  endfunction

  // two bcd digits, saturating at 99
  function automatic int unsigned bcd_clamped(input int unsigned v);
    int unsigned c;
    c = (v > BcdCeiling) ? BcdCeiling : v;
    return ((c / 10) << 4) | (c % 10);
  endfunction

  // expected result word for one calendar word
  function automatic out_word_t predict_time_words(input in_word_t w);
    out_word_t   r;
    bit          leap;
    int unsigned yday;
    int unsigned m;
    int unsigned yd_bcd;
    r = '0;
    leap = is_leap_year(w.year_value);
    // rejected dates leave every field at zero
    if (w.month_num == 0 || w.month_num > 12 || w.day_num == 0) return r;
    if (w.day_num > month_days(w.month_num, leap)) return r;
    yday = w.day_num;
    for (m = 1; m < w.month_num; m++) yday += month_days(m, leap);
    yd_bcd = (((yday / 100) % 10) << 8) | (((yday / 10) % 10) << 4) | (yday % 10);
    r.date_valid = 1'b1;
    r.year_day_word = Word0W'((bcd_clamped(w.year_value % 100) << 10) | (yd_bcd & YdayMask));
    // month and day fields overlap on purpose, ored as they fall
    r.month_day_week_word = Word1W'((bcd_clamped(w.month_num) << 13) |
                                    (bcd_clamped(w.day_num) << 7) |
                                    (w.weekday_code & WeekMask));
    r.hms_word = Word2W'((bcd_clamped(w.hour_num) << 14) |
                         (bcd_clamped(w.minute_num) << 7) |
                         bcd_clamped(w.second_num));
    r.encode_enable_out    = w.encode_enable_in;
    r.decode_enable_out    = w.decode_enable_in;
    r.pps_clear_enable_out = w.pps_clear_enable_in;
    return r;
  endfunction

  function automatic in_word_t build_word(input int unsigned year, input int unsigned month,
                                          input int unsigned day, input int unsigned week,
                                          input int unsigned hour, input int unsigned minute,
                                          input int unsigned second, input logic [2:0] flags);
    in_word_t w;
    w.year_value          = YearW'(year);
    w.month_num           = ByteW'(month);
    w.day_num             = ByteW'(day);
    w.weekday_code        = ByteW'(week);
    w.hour_num            = ByteW'(hour);
    w.minute_num          = ByteW'(minute);
    w.second_num          = ByteW'(second);
    w.encode_enable_in    = flags[2];
    w.decode_enable_in    = flags[1];
    w.pps_clear_enable_in = flags[0];
    return w;
  endfunction

  // random calendar word; well-formed ones carry a real date
  function automatic in_word_t random_word(input bit well_formed);
    in_word_t    w;
    int unsigned year;
    int unsigned month;
    int unsigned day;
    int unsigned span;
    case ($urandom_range(0, 7))
      0, 1:    year = $urandom_range(0, 16383);          // beyond four digits too
      2:       year = $urandom_range(0, 163) * 100;      // century years
      default: year = $urandom_range(0, 9999);
    endcase
    if (well_formed) begin
      month = $urandom_range(1, 12);
      span = month_days(month, is_leap_year(year));
      // lean on the last day of the month
      day = ($urandom_range(0, 3) == 0) ? span : $urandom_range(1, span);
    end else if ($urandom_range(0, 1) == 0) begin
      month = $urandom_range(0, 255);
      day = $urandom_range(0, 255);
    end else begin
      // near misses around the month and day limits
      month = $urandom_range(0, 13);
      day = $urandom_range(0, 32);
    end
    w = build_word(year, month, day, $urandom_range(0, 255), 0, 0, 0, 3'($urandom));
    if ($urandom_range(0, 3) == 0) begin
      w.hour_num   = ByteW'($urandom_range(0, 255));
      w.minute_num = ByteW'($urandom_range(0, 255));
      w.second_num = ByteW'($urandom_range(0, 255));
    end else begin
      w.hour_num   = ByteW'($urandom_range(0, 99));
      w.minute_num = ByteW'($urandom_range(0, 99));
      w.second_num = ByteW'($urandom_range(0, 99));
    end
    return w;
  endfunction

  // offer one word after a random gap and hold it until the block takes it;
  // valid stays high on return so back-to-back words need no gap
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    out_word_t   want;
    gap = send_no_gap ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= w;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    want = predict_time_words(w);
    pending_words.push_back(want);
    if (want.date_valid) good_dates_sent++;
    else bad_dates_sent++;
  endtask

  // sender holds off until every owed result word has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    wait (pending_words.size() == 0);
    @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    results_checked++;
    if (pending_words.size() == 0) begin
      $error("result word with nothing pending: 0x%0h", got);
      mismatch_count++;
    end else begin
      want = pending_words.pop_front();
      compare_field("date_valid", 32'(want.date_valid), 32'(got.date_valid));
      compare_field("year_day_word", 32'(want.year_day_word), 32'(got.year_day_word));
      compare_field("month_day_week_word", 32'(want.month_day_week_word),
                    32'(got.month_day_week_word));
      compare_field("hms_word", 32'(want.hms_word), 32'(got.hms_word));
      compare_field("encode_enable_out", 32'(want.encode_enable_out),
                    32'(got.encode_enable_out));
      compare_field("decode_enable_out", 32'(want.decode_enable_out),
                    32'(got.decode_enable_out));
      compare_field("pps_clear_enable_out", 32'(want.pps_clear_enable_out),
                    32'(got.pps_clear_enable_out));
    end
  endtask

  // result side: random stall before each word, then take it and check it
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = sink_no_stall ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      check_result(out_ch.payload);
    end
  end

  // zero and all-ones words, byte clamping edges, weekday bits, every flag combination
  task automatic test_field_extremes();
    send_word(build_word(0, 0, 0, 0, 0, 0, 0, 3'b000));
    send_word(build_word(16383, 255, 255, 255, 255, 255, 255, 3'b111));
    // year 0 is a leap year under the 400 rule
    send_word(build_word(0, 2, 29, 8'h00, 0, 0, 0, 3'b100));
    send_word(build_word(16383, 12, 31, 8'hFF, 99, 99, 99, 3'b010));
    send_word(build_word(9999, 1, 1, 8'h80, 100, 100, 100, 3'b001));
    send_word(build_word(10000, 7, 15, 8'h7F, 255, 0, 128, 3'b101));
    send_word(build_word(2023, 5, 10, 8'h55, 23, 59, 60, 3'b011));
    send_word(build_word(2023, 5, 10, 8'hAA, 0, 255, 1, 3'b110));
  endtask

  // gregorian leap rule, including century years and the last day of the year
  task automatic test_leap_years();
    send_word(build_word(2024, 2, 29, 1, 12, 0, 0, 3'b111));
    send_word(build_word(2023, 2, 29, 2, 12, 0, 0, 3'b111));
    send_word(build_word(1900, 2, 29, 3, 12, 0, 0, 3'b111));
    send_word(build_word(1900, 2, 28, 4, 12, 0, 0, 3'b111));
    send_word(build_word(2000, 2, 29, 5, 12, 0, 0, 3'b111));
    send_word(build_word(2024, 12, 31, 6, 23, 59, 59, 3'b000));
    send_word(build_word(2023, 12, 31, 0, 23, 59, 59, 3'b000));
    send_word(build_word(12000, 3, 1, 1, 0, 0, 0, 3'b010));
  endtask

  // rejected dates: month out of range, day zero, day past the month end
  task automatic test_invalid_dates();
    send_word(build_word(2021, 0, 10, 1, 1, 1, 1, 3'b111));
    send_word(build_word(2021, 13, 10, 1, 1, 1, 1, 3'b111));
    send_word(build_word(2021, 6, 0, 1, 1, 1, 1, 3'b111));
    send_word(build_word(2021, 4, 31, 1, 1, 1, 1, 3'b111));
    send_word(build_word(2021, 1, 32, 1, 1, 1, 1, 3'b111));
  endtask

  // a back-to-back burst, then the sender waits for the pipe to empty
  task automatic test_drain_pause();
    int unsigned k;
    send_no_gap = 1'b1;
    for (k = 0; k < 4; k++) send_word(random_word(1'b1));
    drain_results();
    send_no_gap = 1'b0;
  endtask

  // mostly real dates with random content, a quarter noise and near misses;
  // idling modes change every block so some stretches run with no gaps at all
  task automatic test_random_words();
    int unsigned n;
    int unsigned mode;
    for (n = 0; n < RandomWords; n++) begin
      if (n % BlockWords == 0) begin
        mode = $urandom_range(0, 3);
        send_no_gap = mode[0];
        sink_no_stall = mode[1];
      end
      if (n != 0 && n % DrainEvery == 0) drain_results();
      send_word(random_word($urandom_range(0, 3) != 0));
    end
    send_no_gap = 1'b0;
    sink_no_stall = 1'b0;
  endtask

  // main sequence
  initial begin : main_sequence
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_leap_years();
    test_invalid_dates();
    test_drain_pause();
    test_random_words();

    // all words accepted: let the pipe empty, then watch for stray results
    in_ch.valid <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (TailCycles) @(posedge clk);

    $display("covered %0d words: %0d real dates, %0d rejected, %0d result words checked",
             good_dates_sent + bad_dates_sent, good_dates_sent, bad_dates_sent,
             results_checked);
    $display("leap and century years, bcd clamping and stalls on both sides exercised");
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // hard limit, far above the slowest correct run
  initial begin : watchdog
    #5_000_000;
    $error("timed out with %0d result words outstanding", pending_words.size());
    $display("testbench: done, errors");
    $finish;
  end

endmodule
